// ===== rtl/core/bdh_pkg.sv =====
// Shared types and constants for the button debounce and hold event unit.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package bdh_pkg;

	localparam int NUM_SWITCHES_DEF = 5;
	localparam int PIN_W = 5;
	localparam int IDX_W = 3;
	localparam int CNT_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd5;
	localparam logic [CNT_W-1:0] HOLD_RST = 8'd100;
	localparam logic [CNT_W-1:0] REPEAT_RST = 8'd150;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_HOLD = 2'd1,
		REG_REPEAT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_PRESS = 2'd0,
		EV_RELEASE = 2'd1,
		EV_HOLD = 2'd2,
		EV_HOLD_RELEASE = 2'd3
	} ev_code_t;

	typedef struct packed {
		logic [CNT_W-1:0] debounce_ticks;
		logic [CNT_W-1:0] hold_ticks;
		logic [CNT_W-1:0] repeat_ticks;
	} cfg_t;

	typedef struct packed {
		logic hit;
		ev_code_t code;
	} lane_event_t;

endpackage

`default_nettype wire

// ===== rtl/core/button_debounce_hold_events_unit.sv =====
// Top level of the button debounce and hold event unit.
// Holds the configuration registers; instantiates bdh_lane and bdh_serializer, uses bdh_pkg.
//
// Usage:
// Each transfer on the tick channel (tick_valid/tick_ready, payload pin_levels) is one timer
// tick with the raw level of every button, 0 pressed and 1 released. Switches beyond the
// five input bits read as pressed. The tick updates all switch lanes at the edge where it is
// transferred and yields zero to NUM_SWITCHES events. These leave on the event channel
// (event_valid/event_ready) one per cycle in switch order while the receiver takes them;
// last_event marks the final event of a tick. A quiet tick gives no transfer on the event
// channel. The events of a tick wait in the pending event buffer and move from there to the
// output register, which shows them. A tick with events occupies the buffer until its
// last event has moved to the output register, so ticks are taken every cycle when quiet
// and otherwise only as the buffer drains. The next tick is taken in the cycle in which the
// last pending event moves to the output register, while that event may still wait for the
// receiver. When the receiver stalls, the output register holds its event and tick_ready
// stays low until the buffer drains.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the next edge;
// index 0 debounce ticks, 1 hold ticks, 2 repeat ticks, other indexes are ignored.
// Reset sets the registers to 5, 100 and 150, all switches released, counters cleared.
`default_nettype none

module button_debounce_hold_events_unit #(
	parameter int NUM_SWITCHES = bdh_pkg::NUM_SWITCHES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [bdh_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [bdh_pkg::CNT_W-1:0] cfg_data,
	input wire logic tick_valid,
	output logic tick_ready,
	input wire logic [bdh_pkg::PIN_W-1:0] pin_levels,
	output logic event_valid,
	input wire logic event_ready,
	output logic [bdh_pkg::IDX_W-1:0] switch_index,
	output logic [1:0] event_code,
	output logic last_event
);

	bdh_pkg::cfg_t cfg_q;
	bdh_pkg::lane_event_t [NUM_SWITCHES-1:0] lane_ev;
	logic tick_en;

	assign tick_en = tick_valid && tick_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= bdh_pkg::DEBOUNCE_RST;
			cfg_q.hold_ticks <= bdh_pkg::HOLD_RST;
			cfg_q.repeat_ticks <= bdh_pkg::REPEAT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				bdh_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ticks <= cfg_data;
				end
				bdh_pkg::REG_HOLD: begin
					cfg_q.hold_ticks <= cfg_data;
				end
				bdh_pkg::REG_REPEAT: begin
					cfg_q.repeat_ticks <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar g = 0; g < NUM_SWITCHES; g++) begin : g_lane
		logic pin;
		if (g < bdh_pkg::PIN_W) begin : g_pin
			assign pin = pin_levels[g];
		end else begin : g_nopin
			assign pin = 1'b0;
		end

		bdh_lane u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.tick_en(tick_en),
			.pin(pin),
			.cfg(cfg_q),
			.lane_ev(lane_ev[g])
		);
	end

	bdh_serializer #(
		.NUM_SWITCHES(NUM_SWITCHES)
	) u_serializer (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_ready(tick_ready),
		.lane_ev(lane_ev),
		.event_valid(event_valid),
		.event_ready(event_ready),
		.switch_index(switch_index),
		.event_code(event_code),
		.last_event(last_event)
	);

endmodule

`default_nettype wire

// ===== rtl/core/bdh_lane.sv =====
// One switch lane: debounce counter, accepted level and hold counter.
// Computes the event of the current tick; depends on bdh_pkg.
`default_nettype none

module bdh_lane (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic tick_en,
	input wire logic pin,
	input wire bdh_pkg::cfg_t cfg,
	output bdh_pkg::lane_event_t lane_ev
);

	logic level_q;
	logic [bdh_pkg::CNT_W-1:0] debounce_q;
	logic [bdh_pkg::CNT_W-1:0] hold_q;

	logic level_n;
	logic [bdh_pkg::CNT_W-1:0] debounce_n;
	logic [bdh_pkg::CNT_W-1:0] hold_n;
	logic [bdh_pkg::CNT_W-1:0] debounce_inc;
	logic [bdh_pkg::CNT_W-1:0] hold_inc;

	assign debounce_inc = debounce_q + bdh_pkg::CNT_W'(1);
	assign hold_inc = hold_q + bdh_pkg::CNT_W'(1);

	always_comb begin
		level_n = level_q;
		debounce_n = '0;
		hold_n = hold_q;
		lane_ev.hit = 1'b0;
		lane_ev.code = bdh_pkg::EV_PRESS;

		if (pin != level_q) begin
			if (debounce_inc == cfg.debounce_ticks) begin
				level_n = pin;
			end else begin
				debounce_n = debounce_inc;
			end
		end

		if (!level_n && level_q) begin
			hold_n = '0;
			lane_ev.hit = 1'b1;
			lane_ev.code = bdh_pkg::EV_PRESS;
		end else if (level_n && !level_q) begin
			lane_ev.hit = 1'b1;
			lane_ev.code = (hold_q < cfg.hold_ticks) ? bdh_pkg::EV_RELEASE
				: bdh_pkg::EV_HOLD_RELEASE;
		end else if (!level_n && !level_q) begin
			if (hold_q < cfg.repeat_ticks) begin
				hold_n = hold_inc;
				if (hold_inc == cfg.hold_ticks) begin
					lane_ev.hit = 1'b1;
					lane_ev.code = bdh_pkg::EV_HOLD;
				end
				if (hold_inc == cfg.repeat_ticks) begin
					lane_ev.hit = 1'b1;
					lane_ev.code = bdh_pkg::EV_HOLD;
					hold_n = cfg.hold_ticks;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b1;
			debounce_q <= '0;
			hold_q <= '0;
		end else if (tick_en) begin
			level_q <= level_n;
			debounce_q <= debounce_n;
			hold_q <= hold_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bdh_serializer.sv =====
// Pending event buffer and output register; one event per cycle in switch order unless
// the receiver stalls. Depends on bdh_pkg.
`default_nettype none

module bdh_serializer #(
	parameter int NUM_SWITCHES = bdh_pkg::NUM_SWITCHES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic tick_valid,
	output logic tick_ready,
	input wire bdh_pkg::lane_event_t [NUM_SWITCHES-1:0] lane_ev,
	output logic event_valid,
	input wire logic event_ready,
	output logic [bdh_pkg::IDX_W-1:0] switch_index,
	output logic [1:0] event_code,
	output logic last_event
);

	logic [NUM_SWITCHES-1:0] pending_q;
	bdh_pkg::ev_code_t [NUM_SWITCHES-1:0] code_q;

	logic [NUM_SWITCHES-1:0] pick;
	logic [NUM_SWITCHES-1:0] rest;
	logic [NUM_SWITCHES-1:0] hit_vec;
	logic [bdh_pkg::IDX_W-1:0] pick_idx;
	logic [1:0] pick_code;
	logic emit;
	logic accept;

	assign pick = pending_q & (~pending_q + NUM_SWITCHES'(1));
	assign rest = pending_q & ~pick;
	assign emit = (pending_q != '0) && (!event_valid || event_ready);
	assign tick_ready = (pending_q == '0) || (emit && (rest == '0));
	assign accept = tick_valid && tick_ready;

	always_comb begin
		pick_idx = '0;
		pick_code = '0;
		for (int i = 0; i < NUM_SWITCHES; i++) begin
			hit_vec[i] = lane_ev[i].hit;
			if (pick[i]) begin
				pick_idx = pick_idx | bdh_pkg::IDX_W'(i);
				pick_code = pick_code | code_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (accept) begin
			pending_q <= hit_vec;
		end else if (emit) begin
			pending_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NUM_SWITCHES; i++) begin
				code_q[i] <= lane_ev[i].code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_valid <= 1'b0;
		end else if (emit) begin
			event_valid <= 1'b1;
		end else if (event_ready) begin
			event_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			switch_index <= pick_idx;
			event_code <= pick_code;
			last_event <= (rest == '0);
		end
	end

	// A shown event that is not the last of its tick always has successors pending.
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !last_event |-> pending_q != '0)
		else $error("non-last event shown with nothing pending");

	// An emitted event leaves the buffer unless a new tick reloads it.
	a_pick_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !accept |=> (pending_q & $past(pick)) == '0)
		else $error("emitted event still pending");

	// A tick is never taken over events that stay pending.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (pending_q == '0) || (emit && rest == '0))
		else $error("tick transfer would drop pending events");

endmodule

`default_nettype wire
